// ----- hdl/register_write_command_encoder_assert.svh -----
// assertion macros for the command encoder checker
`ifndef REGISTER_WRITE_COMMAND_ENCODER_ASSERT_SVH
`define REGISTER_WRITE_COMMAND_ENCODER_ASSERT_SVH

// same-cycle implication
`define RWCE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwce check failed");

// next-cycle implication
`define RWCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwce check failed");

`endif

// ----- hdl/rwce_pkg.sv -----
package rwce_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int UC_ADDR_W    = 5;
  localparam int LEFT_W       = 13;
  localparam logic [LEFT_W-1:0] DELAY_MAX = 13'd8160;

  localparam logic [7:0] OP_SOFS       = 8'h10;
  localparam logic [7:0] OP_SLEN       = 8'h20;
  localparam logic [7:0] OP_FREQ       = 8'h30;
  localparam logic [7:0] OP_WTMODE     = 8'h40;
  localparam logic [7:0] OP_LOOP       = 8'h50;
  localparam logic [7:0] OP_WTNUM      = 8'h60;
  localparam logic [7:0] OP_WAVE       = 8'h70;
  localparam logic [7:0] OP_DUTY       = 8'h80;
  localparam logic [7:0] OP_WAIT_SHORT = 8'h90;
  localparam logic [7:0] OP_NOISE_LOAD = 8'hA1;
  localparam logic [7:0] OP_NOISE_FB   = 8'hA2;
  localparam logic [7:0] OP_NOISE_FREQ = 8'hA3;
  localparam logic [7:0] OP_WAIT_LONG  = 8'hB0;
  localparam logic [7:0] OP_ACC        = 8'hFB;
  localparam logic [7:0] OP_VOL        = 8'hFC;
  localparam logic [7:0] OP_PANR       = 8'hFD;
  localparam logic [7:0] OP_PANL       = 8'hFE;
  localparam logic [7:0] OP_END        = 8'hFF;
  localparam logic [7:0] WAIT_FULL     = 8'hFF;

  typedef enum logic [3:0] {
    MODE_SOFS     = 4'd0,
    MODE_SLEN     = 4'd1,
    MODE_FREQ     = 4'd2,
    MODE_WTMODE   = 4'd3,
    MODE_LOOP     = 4'd4,
    MODE_VOL      = 4'd5,
    MODE_PANR     = 4'd6,
    MODE_PANL     = 4'd7,
    MODE_ACC      = 4'd8,
    MODE_NOISE_FB = 4'd9,
    MODE_NOISE_LD = 4'd10,
    MODE_WTNUM    = 4'd11,
    MODE_WAVE     = 4'd12,
    MODE_DUTY     = 4'd13,
    MODE_DELAY    = 4'd14,
    MODE_END      = 4'd15
  } mode_e;

  typedef enum logic [3:0] {
    SRC_CONST,
    SRC_HI4,
    SRC_WT,
    SRC_NZ,
    SRC_WAVE,
    SRC_FREQ,
    SRC_B0,
    SRC_B1,
    SRC_B2,
    SRC_B3,
    SRC_SHORT,
    SRC_LEFT
  } src_e;

  typedef enum logic [2:0] {
    FL_NEXT,
    FL_GOTO,
    FL_END,
    FL_END_IF_ZERO,
    FL_END_IF_BIG,
    FL_GOTO_IF_LE255,
    FL_GOTO_IF_LT16
  } flow_e;

  typedef logic [UC_ADDR_W-1:0] uc_addr_t;

  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [7:0] konst;
    logic       last;
    logic       sub;
    flow_e      flow;
    uc_addr_t   target;
  } ctrl_t;

  typedef struct packed {
    logic left_zero;
    logic left_le255;
    logic left_lt16;
    logic wt_big;
  } status_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [2:0]  chan_index;
    logic [31:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } res_t;

  localparam uc_addr_t A_SOFS   = 5'd0;
  localparam uc_addr_t A_W16    = 5'd1;
  localparam uc_addr_t A_SLEN   = 5'd3;
  localparam uc_addr_t A_FREQ   = 5'd4;
  localparam uc_addr_t A_W32    = 5'd5;
  localparam uc_addr_t A_WTMODE = 5'd9;
  localparam uc_addr_t A_LOOP   = 5'd10;
  localparam uc_addr_t A_VOL    = 5'd11;
  localparam uc_addr_t A_PANR   = 5'd12;
  localparam uc_addr_t A_PANL   = 5'd13;
  localparam uc_addr_t A_W8     = 5'd14;
  localparam uc_addr_t A_ACC    = 5'd15;
  localparam uc_addr_t A_NFB    = 5'd16;
  localparam uc_addr_t A_NLD    = 5'd17;
  localparam uc_addr_t A_WTNUM  = 5'd18;
  localparam uc_addr_t A_WAVE   = 5'd20;
  localparam uc_addr_t A_DUTY   = 5'd21;
  localparam uc_addr_t A_DELAY  = 5'd22;
  localparam uc_addr_t A_DLOOP  = 5'd23;
  localparam uc_addr_t A_DREM   = 5'd26;
  localparam uc_addr_t A_DSHORT = 5'd29;
  localparam uc_addr_t A_END    = 5'd30;

  function automatic ctrl_t cw(logic e, src_e s, logic [7:0] k, logic l, logic sb,
                               flow_e f, uc_addr_t t);
    ctrl_t c;
    c.emit   = e;
    c.src    = s;
    c.konst  = k;
    c.last   = l;
    c.sub    = sb;
    c.flow   = f;
    c.target = t;
    return c;
  endfunction

  function automatic uc_addr_t entry(logic [3:0] mode);
    uc_addr_t a;
    case (mode)
      MODE_SOFS:     a = A_SOFS;
      MODE_SLEN:     a = A_SLEN;
      MODE_FREQ:     a = A_FREQ;
      MODE_WTMODE:   a = A_WTMODE;
      MODE_LOOP:     a = A_LOOP;
      MODE_VOL:      a = A_VOL;
      MODE_PANR:     a = A_PANR;
      MODE_PANL:     a = A_PANL;
      MODE_ACC:      a = A_ACC;
      MODE_NOISE_FB: a = A_NFB;
      MODE_NOISE_LD: a = A_NLD;
      MODE_WTNUM:    a = A_WTNUM;
      MODE_WAVE:     a = A_WAVE;
      MODE_DUTY:     a = A_DUTY;
      MODE_DELAY:    a = A_DELAY;
      default:       a = A_END;
    endcase
    return a;
  endfunction

  function automatic ctrl_t ucode(uc_addr_t a);
    ctrl_t c;
    case (a)
      5'd0:    c = cw(1'b1, SRC_HI4,   OP_SOFS,       1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd1:    c = cw(1'b1, SRC_B0,    8'h00,         1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd2:    c = cw(1'b1, SRC_B1,    8'h00,         1'b1, 1'b0, FL_END,  A_SOFS);
      5'd3:    c = cw(1'b1, SRC_HI4,   OP_SLEN,       1'b0, 1'b0, FL_GOTO, A_W16);
      5'd4:    c = cw(1'b1, SRC_FREQ,  8'h00,         1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd5:    c = cw(1'b1, SRC_B0,    8'h00,         1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd6:    c = cw(1'b1, SRC_B1,    8'h00,         1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd7:    c = cw(1'b1, SRC_B2,    8'h00,         1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd8:    c = cw(1'b1, SRC_B3,    8'h00,         1'b1, 1'b0, FL_END,  A_SOFS);
      5'd9:    c = cw(1'b1, SRC_NZ,    OP_WTMODE,     1'b1, 1'b0, FL_END,  A_SOFS);
      5'd10:   c = cw(1'b1, SRC_NZ,    OP_LOOP,       1'b1, 1'b0, FL_END,  A_SOFS);
      5'd11:   c = cw(1'b1, SRC_CONST, OP_VOL,        1'b0, 1'b0, FL_GOTO, A_W8);
      5'd12:   c = cw(1'b1, SRC_CONST, OP_PANR,       1'b0, 1'b0, FL_GOTO, A_W8);
      5'd13:   c = cw(1'b1, SRC_CONST, OP_PANL,       1'b0, 1'b0, FL_GOTO, A_W8);
      5'd14:   c = cw(1'b1, SRC_B0,    8'h00,         1'b1, 1'b0, FL_END,  A_SOFS);
      5'd15:   c = cw(1'b1, SRC_CONST, OP_ACC,        1'b0, 1'b0, FL_GOTO, A_W32);
      5'd16:   c = cw(1'b1, SRC_CONST, OP_NOISE_FB,   1'b0, 1'b0, FL_GOTO, A_W32);
      5'd17:   c = cw(1'b1, SRC_CONST, OP_NOISE_LOAD, 1'b0, 1'b0, FL_GOTO, A_W32);
      5'd18:   c = cw(1'b0, SRC_CONST, 8'h00,         1'b0, 1'b0, FL_END_IF_BIG, A_SOFS);
      5'd19:   c = cw(1'b1, SRC_WT,    OP_WTNUM,      1'b0, 1'b0, FL_GOTO, A_W8);
      5'd20:   c = cw(1'b1, SRC_WAVE,  OP_WAVE,       1'b1, 1'b0, FL_END,  A_SOFS);
      5'd21:   c = cw(1'b1, SRC_CONST, OP_DUTY,       1'b0, 1'b0, FL_GOTO, A_W8);
      5'd22:   c = cw(1'b0, SRC_CONST, 8'h00,         1'b0, 1'b0, FL_END_IF_ZERO, A_SOFS);
      5'd23:   c = cw(1'b0, SRC_CONST, 8'h00,         1'b0, 1'b0, FL_GOTO_IF_LE255, A_DREM);
      5'd24:   c = cw(1'b1, SRC_CONST, OP_WAIT_LONG,  1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd25:   c = cw(1'b1, SRC_CONST, WAIT_FULL,     1'b0, 1'b1, FL_GOTO, A_DLOOP);
      5'd26:   c = cw(1'b0, SRC_CONST, 8'h00,         1'b0, 1'b0, FL_GOTO_IF_LT16, A_DSHORT);
      5'd27:   c = cw(1'b1, SRC_CONST, OP_WAIT_LONG,  1'b0, 1'b0, FL_NEXT, A_SOFS);
      5'd28:   c = cw(1'b1, SRC_LEFT,  8'h00,         1'b1, 1'b0, FL_END,  A_SOFS);
      5'd29:   c = cw(1'b1, SRC_SHORT, OP_WAIT_SHORT, 1'b1, 1'b0, FL_END,  A_SOFS);
      5'd30:   c = cw(1'b1, SRC_CONST, OP_END,        1'b1, 1'b0, FL_END,  A_SOFS);
      default: c = cw(1'b0, SRC_CONST, 8'h00,         1'b0, 1'b0, FL_END,  A_SOFS);
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/register_write_command_encoder.sv -----
// Encodes one register write per start into a little-endian byte command. A write is
// taken when start_i is high and busy_o is low; busy_o stays high while the microcode
// runs, one program step per cycle, and the next write can be taken at the earliest in
// the cycle after the last step. Each byte appears for one cycle on res_o with
// res_valid_o, in the cycle after its step, and the receiver cannot stall it; last_byte
// marks the final byte of a write. Step counts: one per byte for most kinds (1 to 5),
// one more for wavetable numbers, one step for writes that produce nothing, and
// 3*pairs + 4 or 5 steps for a frame delay, whose remainder loop runs three steps per
// wait-long pair (up to 98 steps).
module register_write_command_encoder #(
  parameter int NUM_CHANNELS = rwce_pkg::NUM_CHANNELS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  rwce_pkg::cmd_t cmd_i,
  output logic           res_valid_o,
  output rwce_pkg::res_t res_o
);

  rwce_pkg::uc_addr_t pc;
  rwce_pkg::ctrl_t    ctrl;
  rwce_pkg::status_t  status;
  logic               run;
  logic               accept;

  rwce_ucode_rom u_rom (
    .addr_i (pc),
    .ctrl_o (ctrl)
  );

  rwce_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .mode_i   (cmd_i.mode),
    .ctrl_i   (ctrl),
    .status_i (status),
    .pc_o     (pc),
    .run_o    (run),
    .accept_o (accept)
  );

  rwce_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .run_i       (run),
    .cmd_i       (cmd_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign busy_o = run;

endmodule

// ----- hdl/rwce_ucode_rom.sv -----
module rwce_ucode_rom (
  input  rwce_pkg::uc_addr_t addr_i,
  output rwce_pkg::ctrl_t    ctrl_o
);

  assign ctrl_o = rwce_pkg::ucode(addr_i);

endmodule

// ----- hdl/rwce_sequencer.sv -----
module rwce_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [3:0]         mode_i,
  input  rwce_pkg::ctrl_t    ctrl_i,
  input  rwce_pkg::status_t  status_i,
  output rwce_pkg::uc_addr_t pc_o,
  output logic               run_o,
  output logic               accept_o
);

  rwce_pkg::uc_addr_t pc_q, pc_d, pc_inc;
  logic               run_q, run_d;
  logic               stop;
  logic               jump;

  assign accept_o = start_i & ~run_q;
  assign pc_inc   = pc_q + 1'b1;

  always_comb begin
    stop = 1'b0;
    jump = 1'b0;
    case (ctrl_i.flow)
      rwce_pkg::FL_NEXT:          ;
      rwce_pkg::FL_GOTO:          jump = 1'b1;
      rwce_pkg::FL_END:           stop = 1'b1;
      rwce_pkg::FL_END_IF_ZERO:   stop = status_i.left_zero;
      rwce_pkg::FL_END_IF_BIG:    stop = status_i.wt_big;
      rwce_pkg::FL_GOTO_IF_LE255: jump = status_i.left_le255;
      rwce_pkg::FL_GOTO_IF_LT16:  jump = status_i.left_lt16;
      default:                    stop = 1'b1;
    endcase
  end

  always_comb begin
    pc_d  = pc_q;
    run_d = run_q;
    if (accept_o) begin
      pc_d  = rwce_pkg::entry(mode_i);
      run_d = 1'b1;
    end else if (run_q) begin
      if (stop) begin
        run_d = 1'b0;
      end else if (jump) begin
        pc_d = ctrl_i.target;
      end else begin
        pc_d = pc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      run_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      run_q <= run_d;
    end
  end

  assign pc_o  = pc_q;
  assign run_o = run_q;

endmodule

// ----- hdl/rwce_datapath.sv -----
module rwce_datapath #(
  parameter int NUM_CHANNELS = rwce_pkg::NUM_CHANNELS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              run_i,
  input  rwce_pkg::cmd_t    cmd_i,
  input  rwce_pkg::ctrl_t   ctrl_i,
  output rwce_pkg::status_t status_o,
  output logic              res_valid_o,
  output rwce_pkg::res_t    res_o
);

  logic [31:0]                 value_q, value_d;
  logic                        lastch_q, lastch_d;
  logic [rwce_pkg::LEFT_W-1:0] left_q, left_d;
  logic                        valid_q, valid_d;
  rwce_pkg::res_t              res_q, res_d;
  logic [7:0]                  byte_sel;

  always_comb begin
    value_d  = value_q;
    lastch_d = lastch_q;
    left_d   = left_q;
    if (accept_i) begin
      value_d  = cmd_i.write_value;
      lastch_d = (32'(cmd_i.chan_index) == 32'(NUM_CHANNELS - 1));
      left_d   = (cmd_i.write_value > 32'(rwce_pkg::DELAY_MAX)) ? rwce_pkg::DELAY_MAX
                                                              : cmd_i.write_value[12:0];
    end else if (run_i && ctrl_i.sub) begin
      left_d = left_q - 13'd255;
    end
  end

  always_comb begin
    case (ctrl_i.src)
      rwce_pkg::SRC_CONST: byte_sel = ctrl_i.konst;
      rwce_pkg::SRC_HI4:   byte_sel = ctrl_i.konst | {4'b0, value_q[19:16]};
      rwce_pkg::SRC_WT:    byte_sel = ctrl_i.konst | {4'b0, value_q[11:8]};
      rwce_pkg::SRC_NZ:    byte_sel = ctrl_i.konst | {7'b0, |value_q};
      rwce_pkg::SRC_WAVE:  byte_sel = ctrl_i.konst | {6'b0, value_q[1:0]};
      rwce_pkg::SRC_FREQ:  byte_sel = lastch_q ? rwce_pkg::OP_NOISE_FREQ : rwce_pkg::OP_FREQ;
      rwce_pkg::SRC_B0:    byte_sel = value_q[7:0];
      rwce_pkg::SRC_B1:    byte_sel = value_q[15:8];
      rwce_pkg::SRC_B2:    byte_sel = value_q[23:16];
      rwce_pkg::SRC_B3:    byte_sel = value_q[31:24];
      rwce_pkg::SRC_SHORT: byte_sel = ctrl_i.konst | {4'b0, left_q[3:0]};
      rwce_pkg::SRC_LEFT:  byte_sel = left_q[7:0];
      default:             byte_sel = ctrl_i.konst;
    endcase
  end

  assign valid_d         = run_i & ctrl_i.emit;
  assign res_d.out_byte  = byte_sel;
  assign res_d.last_byte = ctrl_i.last;

  assign status_o.left_zero  = (left_q == '0);
  assign status_o.left_le255 = (left_q <= 13'd255);
  assign status_o.left_lt16  = (left_q < 13'd16);
  assign status_o.wt_big     = |value_q[31:12];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    lastch_q <= lastch_d;
    left_q   <= left_d;
    res_q    <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hdl/rwce_checker.sv -----
`include "register_write_command_encoder_assert.svh"

module rwce_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input rwce_pkg::cmd_t cmd_i,
  input logic           res_valid_o,
  input rwce_pkg::res_t res_o
);

  logic unused_cmd;
  assign unused_cmd = ^cmd_i;

  // a word only comes out of a running program
  `RWCE_ASSERT_IMPL(a_word_from_run, clk_i, rst_ni, res_valid_o, $past(busy_o))
  // an accepted write starts the program
  `RWCE_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // final word leaves the block ready
  `RWCE_ASSERT_IMPL(a_last_idle, clk_i, rst_ni, res_valid_o && res_o.last_byte, !busy_o)
  // more words follow a word that is not final
  `RWCE_ASSERT_IMPL(a_more_busy, clk_i, rst_ni, res_valid_o && !res_o.last_byte, busy_o)

endmodule

bind register_write_command_encoder rwce_checker u_rwce_checker (.*);
